/* design/phc_pkg.sv */
// ----------------------------------------------------------------------------
// Pump hysteresis controller package
// Beat types, configuration register indexes and controller state record.
// ----------------------------------------------------------------------------
package phc_pkg;

  localparam int unsigned PRESSURE_W = 16;
  localparam int unsigned THRESH_W   = 15;
  localparam int unsigned SECONDS_W  = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned MS_W       = 22;

  localparam logic [MS_W-1:0] MS_PER_SECOND = MS_W'(1000);

  localparam logic [THRESH_W-1:0]  MIN_PRESSURE_RST = THRESH_W'(200);
  localparam logic [THRESH_W-1:0]  MAX_PRESSURE_RST = THRESH_W'(400);
  localparam logic [SECONDS_W-1:0] LEAK_SECONDS_RST = SECONDS_W'(60);
  localparam logic [SECONDS_W-1:0] WEAK_SECONDS_RST = SECONDS_W'(600);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PRESSURE   = 3'd0,
    CFG_MAX_PRESSURE   = 3'd1,
    CFG_LEAK_SECONDS   = 3'd2,
    CFG_WEAK_SECONDS   = 3'd3,
    CFG_LEAK_ENABLE    = 3'd4
  } cfg_index_t;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_ENABLE = 1'b1
  } action_t;

  typedef struct packed {
    logic                         action;
    logic [TIME_W-1:0]            now_ms;
    logic signed [PRESSURE_W-1:0] pressure;
    logic                         settings_mode;
    logic                         enable_value;
  } in_item_t;

  typedef struct packed {
    logic pump_on;
    logic control_enabled;
    logic leak_fault;
    logic pump_changed;
    logic enable_notified;
  } out_item_t;

  typedef struct packed {
    logic              pump;
    logic              enabled;
    logic              fault;
    logic              awaiting;
    logic [TIME_W-1:0] last_toggle;
    logic [TIME_W-1:0] run_start;
    logic [TIME_W-1:0] await_start;
    logic              changed;
    logic              notified;
  } ctl_state_t;

endpackage

/* design/pump_hysteresis_controller_unit.sv */
// A beat accepted into the input register moves on to the result register
// that drives out_data. Throughput: one beat per cycle while out_ready does
// not stall the output; the single-pass update between them sets this figure.
// Reset (rst_n low, synchronous): pump off, control enabled, no fault,
// timestamps cleared, registers back to their default thresholds and times.
// ----------------------------------------------------------------------------
// Pump hysteresis controller unit
// Bang-bang pump control with toggle interval, leak and run-time supervision.
// ----------------------------------------------------------------------------
module pump_hysteresis_controller_unit #(
  parameter int unsigned MIN_TOGGLE_MS = 1000
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  phc_pkg::in_item_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output phc_pkg::out_item_t                     out_data,
  input  logic                                   cfg_we,
  input  logic [phc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [phc_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam logic [phc_pkg::TIME_W-1:0] MIN_TOGGLE = phc_pkg::TIME_W'(MIN_TOGGLE_MS);

  logic [phc_pkg::THRESH_W-1:0]  min_pressure_r;
  logic [phc_pkg::THRESH_W-1:0]  max_pressure_r;
  logic [phc_pkg::SECONDS_W-1:0] leak_seconds_r;
  logic [phc_pkg::SECONDS_W-1:0] weak_seconds_r;
  logic                          leak_enable_r;

  logic                 in_valid_r;
  phc_pkg::in_item_t    in_item_r;
  logic                 out_valid_r;
  phc_pkg::out_item_t   out_item_r;
  phc_pkg::ctl_state_t  st_r;
  phc_pkg::ctl_state_t  st_nxt;
  logic                 advance;

  logic signed [phc_pkg::PRESSURE_W-1:0] min_s;
  logic signed [phc_pkg::PRESSURE_W-1:0] max_s;
  logic [phc_pkg::TIME_W-1:0]            leak_ms;
  logic [phc_pkg::TIME_W-1:0]            weak_ms;

  function automatic phc_pkg::ctl_state_t drive_pump(
    phc_pkg::ctl_state_t s, logic on, logic [phc_pkg::TIME_W-1:0] now);
    phc_pkg::ctl_state_t r;
    logic [phc_pkg::TIME_W-1:0] gap;
    r   = s;
    gap = now - s.last_toggle;
    if (on != s.pump && !(s.last_toggle != '0 && gap < MIN_TOGGLE)) begin
      r.pump        = on;
      r.last_toggle = now;
      if (on) begin
        r.run_start   = now;
        r.awaiting    = 1'b1;
        r.await_start = now;
      end else begin
        r.awaiting = 1'b0;
      end
      r.changed = 1'b1;
    end
    return r;
  endfunction

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign min_s   = $signed({1'b0, min_pressure_r});
  assign max_s   = $signed({1'b0, max_pressure_r});
  assign leak_ms = phc_pkg::TIME_W'(
    phc_pkg::MS_W'(leak_seconds_r) * phc_pkg::MS_PER_SECOND);
  assign weak_ms = phc_pkg::TIME_W'(
    phc_pkg::MS_W'(weak_seconds_r) * phc_pkg::MS_PER_SECOND);

  always_comb begin
    phc_pkg::ctl_state_t s;
    logic [phc_pkg::TIME_W-1:0] now;
    logic signed [phc_pkg::PRESSURE_W-1:0] p;
    logic tripped;
    s          = st_r;
    s.changed  = 1'b0;
    s.notified = 1'b0;
    now        = in_item_r.now_ms;
    p          = in_item_r.pressure;
    tripped    = 1'b0;
    if (in_item_r.action == phc_pkg::ACT_ENABLE) begin
      s.enabled = in_item_r.enable_value;
      if (!in_item_r.enable_value) begin
        s = drive_pump(s, 1'b0, now);
      end else begin
        s.fault = 1'b0;
      end
      s.notified = 1'b1;
    end else if (!in_item_r.settings_mode) begin
      if (!s.pump && s.enabled && p < min_s) begin
        s = drive_pump(s, 1'b1, now);
      end else if (s.pump && p >= max_s) begin
        s = drive_pump(s, 1'b0, now);
      end
      if (s.pump) begin
        if (s.awaiting) begin
          if (p >= min_s) begin
            s.awaiting = 1'b0;
          end else if (leak_enable_r && (now - s.await_start) >= leak_ms) begin
            s.fault    = 1'b1;
            s.enabled  = 1'b0;
            s          = drive_pump(s, 1'b0, now);
            s.notified = 1'b1;
            tripped    = 1'b1;
          end
        end
        if (!tripped && (now - s.run_start) >= weak_ms) begin
          s = drive_pump(s, 1'b0, now);
        end
      end
    end
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pressure_r <= phc_pkg::MIN_PRESSURE_RST;
      max_pressure_r <= phc_pkg::MAX_PRESSURE_RST;
      leak_seconds_r <= phc_pkg::LEAK_SECONDS_RST;
      weak_seconds_r <= phc_pkg::WEAK_SECONDS_RST;
      leak_enable_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        phc_pkg::CFG_MIN_PRESSURE: min_pressure_r <= cfg_data[phc_pkg::THRESH_W-1:0];
        phc_pkg::CFG_MAX_PRESSURE: max_pressure_r <= cfg_data[phc_pkg::THRESH_W-1:0];
        phc_pkg::CFG_LEAK_SECONDS: leak_seconds_r <= cfg_data[phc_pkg::SECONDS_W-1:0];
        phc_pkg::CFG_WEAK_SECONDS: weak_seconds_r <= cfg_data[phc_pkg::SECONDS_W-1:0];
        phc_pkg::CFG_LEAK_ENABLE:  leak_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{pump: 1'b0, enabled: 1'b1, fault: 1'b0, awaiting: 1'b0,
                       last_toggle: '0, run_start: '0, await_start: '0,
                       changed: 1'b0, notified: 1'b0};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= '{pump_on: st_nxt.pump, control_enabled: st_nxt.enabled,
                      leak_fault: st_nxt.fault, pump_changed: st_nxt.changed,
                      enable_notified: st_nxt.notified};
    end
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Pump hysteresis controller testbench
// Drives sample and command beats through a valid/ready channel, keeps its
// own model of the controller state and checks every result beat field by
// field. A directed table comes first, then random phases with varied
// register settings, random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import phc_pkg::*;

  localparam int unsigned TOGGLE_MS = 1000;
  localparam int unsigned PHASE_BEATS = 180;

  typedef struct {
    bit                    is_cfg;
    in_item_t              beat;
    bit                    known;
    out_item_t             want;
    cfg_index_t            idx;
    logic [CFG_DATA_W-1:0] val;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // model registers and state
  logic [THRESH_W-1:0]  thr_min;
  logic [THRESH_W-1:0]  thr_max;
  logic [SECONDS_W-1:0] leak_s;
  logic [SECONDS_W-1:0] weak_s;
  logic                 leak_en;
  logic                 pump;
  logic                 enabled;
  logic                 fault;
  logic                 awaiting;
  logic [TIME_W-1:0]    last_toggle;
  logic [TIME_W-1:0]    run_start;
  logic [TIME_W-1:0]    await_start;
  logic                 changed;
  logic                 notified;

  out_item_t         outcomes_due[$];
  stim_row_t         script[$];
  logic [TIME_W-1:0] clock_ms;
  int                errors = 0;
  bit                quiet = 1'b0;
  bit                hold_req = 1'b0;

  pump_hysteresis_controller_unit #(.MIN_TOGGLE_MS(TOGGLE_MS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void pump_request(logic want_on, logic [TIME_W-1:0] t);
    if (want_on == pump) return;
    if (last_toggle != 0 && (t - last_toggle) < TOGGLE_MS) return;
    pump = want_on;
    last_toggle = t;
    if (want_on) begin
      run_start = t;
      awaiting = 1'b1;
      await_start = t;
    end else begin
      awaiting = 1'b0;
    end
    changed = 1'b1;
  endfunction

  function automatic void enable_write(logic en, logic [TIME_W-1:0] t);
    enabled = en;
    if (!en) pump_request(1'b0, t);
    else fault = 1'b0;
    notified = 1'b1;
  endfunction

  function automatic void regulate(logic signed [PRESSURE_W-1:0] p, logic [TIME_W-1:0] t);
    int pv, lo, hi;
    logic [TIME_W-1:0] leak_ms, weak_ms;
    pv = p;
    lo = thr_min;
    hi = thr_max;
    if (!pump && enabled && pv < lo) pump_request(1'b1, t);
    else if (pump && pv >= hi) pump_request(1'b0, t);
    if (!pump) return;
    leak_ms = TIME_W'(leak_s) * 32'd1000;
    weak_ms = TIME_W'(weak_s) * 32'd1000;
    if (awaiting) begin
      if (pv >= lo) begin
        awaiting = 1'b0;
      end else if (leak_en && (t - await_start) >= leak_ms) begin
        fault = 1'b1;
        enable_write(1'b0, t);
        return;
      end
    end
    if ((t - run_start) >= weak_ms) pump_request(1'b0, t);
  endfunction

  function automatic out_item_t pump_outcome(in_item_t b);
    out_item_t r;
    changed = 1'b0;
    notified = 1'b0;
    if (b.action == ACT_ENABLE) enable_write(b.enable_value, b.now_ms);
    else if (!b.settings_mode) regulate(b.pressure, b.now_ms);
    r.pump_on = pump;
    r.control_enabled = enabled;
    r.leak_fault = fault;
    r.pump_changed = changed;
    r.enable_notified = notified;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t random_beat();
    in_item_t b;
    int r, a, c, lo, hi;
    r = $urandom_range(0, 99);
    if (r < 85) clock_ms += $urandom_range(0, 1500);
    else if (r < 95) clock_ms += $urandom_range(1500, 20000);
    else if (r < 98) clock_ms += $urandom;
    else clock_ms = $urandom;
    a = thr_min;
    c = thr_max;
    lo = ((a < c) ? a : c) - 300;
    hi = ((a < c) ? c : a) + 300;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    b.now_ms = clock_ms;
    b.action = ($urandom_range(0, 99) < 8) ? ACT_ENABLE : ACT_SAMPLE;
    b.enable_value = ($urandom_range(0, 99) < 70);
    b.settings_mode = ($urandom_range(0, 99) < 6);
    if ($urandom_range(0, 9) == 0) b.pressure = PRESSURE_W'($urandom);
    else b.pressure = PRESSURE_W'(lo + int'($urandom_range(0, hi - lo)));
    return b;
  endfunction

  function automatic void add_beat(action_t act, logic [TIME_W-1:0] t, int p, bit sm, bit en,
                                   bit known, out_item_t want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.beat.action = act;
    row.beat.now_ms = t;
    row.beat.pressure = PRESSURE_W'(p);
    row.beat.settings_mode = sm;
    row.beat.enable_value = en;
    row.known = known;
    row.want = want;
    row.idx = CFG_MIN_PRESSURE;
    row.val = '0;
    script.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_index_t i, int v);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.beat = '0;
    row.known = 1'b0;
    row.want = '0;
    row.idx = i;
    row.val = CFG_DATA_W'(v);
    script.push_back(row);
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 40) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_bit(string field, logic got, logic want);
    if (got !== want) report_mismatch($sformatf("%s got %b want %b", field, got, want));
  endtask

  task automatic send_beat(in_item_t b, bit known, out_item_t want);
    out_item_t predicted;
    int g;
    cfg_we <= 1'b0;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = pump_outcome(b);
    outcomes_due.push_back(known ? want : predicted);
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic cfg_write(cfg_index_t i, logic [CFG_DATA_W-1:0] v);
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    case (i)
      CFG_MIN_PRESSURE: thr_min = v[THRESH_W-1:0];
      CFG_MAX_PRESSURE: thr_max = v[THRESH_W-1:0];
      CFG_LEAK_SECONDS: leak_s = v[SECONDS_W-1:0];
      CFG_WEAK_SECONDS: weak_s = v[SECONDS_W-1:0];
      CFG_LEAK_ENABLE:  leak_en = v[0];
      default: ;
    endcase
  endtask

  task automatic apply_phase(int mn, int mx, int lk, int wk, int en);
    cfg_write(CFG_MIN_PRESSURE, CFG_DATA_W'(mn));
    cfg_write(CFG_MAX_PRESSURE, CFG_DATA_W'(mx));
    cfg_write(CFG_LEAK_SECONDS, CFG_DATA_W'(lk));
    cfg_write(CFG_WEAK_SECONDS, CFG_DATA_W'(wk));
    cfg_write(CFG_LEAK_ENABLE, CFG_DATA_W'(en));
  endtask

  // result bits: pump_on, control_enabled, leak_fault, pump_changed, enable_notified
  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    thr_min = MIN_PRESSURE_RST;
    thr_max = MAX_PRESSURE_RST;
    leak_s = LEAK_SECONDS_RST;
    weak_s = WEAK_SECONDS_RST;
    leak_en = 1'b1;
    pump = 1'b0;
    enabled = 1'b1;
    fault = 1'b0;
    awaiting = 1'b0;
    last_toggle = '0;
    run_start = '0;
    await_start = '0;

    add_beat(ACT_SAMPLE, 5000, 300, 0, 0, 1, 5'b01000);
    add_beat(ACT_SAMPLE, 6000, 100, 0, 1, 1, 5'b11010);
    add_beat(ACT_SAMPLE, 6500, 500, 0, 0, 1, 5'b11000);
    add_beat(ACT_SAMPLE, 7000, 32767, 1, 1, 1, 5'b11000);
    add_beat(ACT_SAMPLE, 7500, 400, 0, 0, 1, 5'b01010);
    add_beat(ACT_ENABLE, 8000, 0, 0, 0, 1, 5'b00001);
    add_beat(ACT_SAMPLE, 10000, -32768, 0, 0, 1, 5'b00000);
    add_beat(ACT_ENABLE, 10500, -1, 1, 1, 1, 5'b01001);
    add_beat(ACT_SAMPLE, 11000, -32768, 0, 0, 1, 5'b11010);
    add_beat(ACT_SAMPLE, 71000, 150, 0, 0, 1, 5'b00111);
    add_beat(ACT_ENABLE, 72000, 0, 0, 1, 1, 5'b01001);
    add_cfg(CFG_WEAK_SECONDS, 0);
    add_cfg(CFG_LEAK_SECONDS, 0);
    add_cfg(CFG_MIN_PRESSURE, 32767);
    add_cfg(CFG_MAX_PRESSURE, 0);
    add_beat(ACT_SAMPLE, 0, 32766, 0, 0, 0, '0);
    add_beat(ACT_ENABLE, 0, 12345, 1, 1, 1, 5'b01001);
    add_cfg(CFG_LEAK_ENABLE, 0);
    add_beat(ACT_SAMPLE, 0, -1, 0, 1, 0, '0);
    add_beat(ACT_SAMPLE, 100, 32767, 0, 0, 0, '0);
    add_cfg(CFG_WEAK_SECONDS, 4095);
    add_cfg(CFG_LEAK_SECONDS, 4095);
    add_cfg(CFG_MIN_PRESSURE, 0);
    add_cfg(CFG_MAX_PRESSURE, 32767);
    add_cfg(CFG_LEAK_ENABLE, 1);
    add_beat(ACT_SAMPLE, 32'hFFFF_FF00, -5, 0, 0, 0, '0);
    add_beat(ACT_SAMPLE, 200, 32767, 0, 0, 0, '0);
    add_beat(ACT_SAMPLE, 1200, 32767, 0, 0, 0, '0);
    add_beat(ACT_SAMPLE, 5000, -1, 0, 0, 0, '0);
    add_beat(ACT_ENABLE, 5500, 0, 0, 0, 0, '0);
    add_beat(ACT_SAMPLE, 7000, 32767, 0, 0, 0, '0);
    add_beat(ACT_ENABLE, 8000, -32768, 1, 1, 1, 5'b01001);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      if (script[k].is_cfg) cfg_write(script[k].idx, script[k].val);
      else send_beat(script[k].beat, script[k].known, script[k].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_phase(200, 400, 3, 8, 1);
        2: apply_phase(32767, 32767, 4095, 4095, 0);
        3: apply_phase(600, 100, 2, 6, 1);
        4: apply_phase(0, 0, 0, 0, 1);
        default: apply_phase($urandom_range(0, 1000), $urandom_range(0, 1000),
                             $urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 1));
      endcase
      quiet = (ph == 1);
      clock_ms = (ph == 4) ? 32'hFFFF_C000 : $urandom;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 3 && n == 30) hold_req = 1'b1;
        send_beat(random_beat(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin : receiver
    int run, g;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold off long enough for the block to back up its input
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        run = quiet ? 1 : $urandom_range(1, 8);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        g = quiet ? 0 : gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = outcomes_due.pop_front();
        check_bit("pump_on", out_data.pump_on, want.pump_on);
        check_bit("control_enabled", out_data.control_enabled, want.control_enabled);
        check_bit("leak_fault", out_data.leak_fault, want.leak_fault);
        check_bit("pump_changed", out_data.pump_changed, want.pump_changed);
        check_bit("enable_notified", out_data.enable_notified, want.enable_notified);
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
design/phc_pkg.sv
design/pump_hysteresis_controller_unit.sv
bench/testbench.sv
